FILE: rtl/core/hbd_pkg.sv
// Shared types and constants for the Huffman bit decoder.
package hbd_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int CODE_WIDTH = 64;
    localparam int BYTE_BITS = 8;
    localparam int LOAD_CODE_BITS = 64;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_DATA = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                       op;
        logic [7:0]                load_symbol;
        logic [LOAD_CODE_BITS-1:0] load_code;
        logic [7:0]                data_byte;
        logic [3:0]                valid_bits;
        logic                      stream_end;
    } item_t;

    typedef struct packed
    {
        logic [7:0] symbol;
        logic       last_of_item;
    } result_t;

    typedef struct packed
    {
        logic take_item;
        logic shift_bit;
        logic scan_step;
        logic take_hit;
        logic finish;
    } cmd_t;

    typedef struct packed
    {
        logic item_load;
        logic item_empty;
        logic hit;
        logic scan_miss;
        logic bits_left;
        logic can_push;
    } status_t;

endpackage

FILE: rtl/core/hbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hbd_ram #(
    parameter int WIDTH = hbd_pkg::CODE_WIDTH,
    parameter int DEPTH = hbd_pkg::TABLE_ENTRIES
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/hbd_datapath.sv
// Datapath: code table, accumulator, table scan, pending symbol and result register.
module hbd_datapath #(
    parameter int TABLE_ENTRIES = hbd_pkg::TABLE_ENTRIES,
    parameter int CODE_WIDTH = hbd_pkg::CODE_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hbd_pkg::item_t   item,
    input  hbd_pkg::cmd_t    cmd,
    output hbd_pkg::status_t status,
    output logic             result_valid,
    input  logic             result_ready,
    output hbd_pkg::result_t result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CODE_WIDTH-1:0] ACC_EMPTY = CODE_WIDTH'(1);

    logic [CODE_WIDTH-1:0]    acc_reg;
    logic [CODE_WIDTH-1:0]    acc_next;
    logic [7:0]               byte_reg;
    logic [3:0]               nbits_reg;
    logic [3:0]               bit_cnt_reg;
    logic                     end_reg;
    logic [TABLE_ENTRIES-1:0] vld_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic                     issue_more_reg;
    logic                     cmp_pending_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     ent_vld_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic                     pend_valid_reg;
    logic [IDX_W-1:0]         pend_idx_reg;
    logic                     result_valid_reg;
    hbd_pkg::result_t         result_reg;

    logic [3:0]            nbits_clamped;
    logic                  sym_in_range;
    logic                  wr_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [CODE_WIDTH-1:0] rd_data;
    logic                  issue;
    logic                  hit;
    logic                  push;
    logic                  push_last;

    assign nbits_clamped = (item.valid_bits > 4'(hbd_pkg::BYTE_BITS))
                         ? 4'(hbd_pkg::BYTE_BITS) : item.valid_bits;
    assign sym_in_range = ({1'b0, item.load_symbol} < 9'(TABLE_ENTRIES));
    assign wr_en = cmd.take_item && (item.op == hbd_pkg::OP_LOAD) && sym_in_range;

    assign rd_addr = cmd.shift_bit ? '0 : scan_idx_reg;
    assign issue = cmd.shift_bit || (cmd.scan_step && issue_more_reg);

    hbd_ram #(
        .WIDTH (CODE_WIDTH),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item.load_symbol[IDX_W-1:0]),
        .wr_data (item.load_code[CODE_WIDTH-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hit = cmp_pending_reg && ent_vld_reg && (rd_data != '0) && (rd_data == acc_reg);
    assign acc_next = {acc_reg[CODE_WIDTH-2:0], byte_reg[7]};

    assign push = (cmd.take_hit || cmd.finish) && pend_valid_reg;
    assign push_last = cmd.finish;

    assign status.item_load = (item.op == hbd_pkg::OP_LOAD);
    assign status.item_empty = (nbits_clamped == 4'd0);
    assign status.hit = hit;
    assign status.scan_miss = cmp_pending_reg && !hit && (cmp_idx_reg == LAST_IDX);
    assign status.bits_left = (bit_cnt_reg != nbits_reg);
    assign status.can_push = !pend_valid_reg || !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= ACC_EMPTY;
            vld_reg <= '0;
            issue_more_reg <= 1'b0;
            cmp_pending_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[item.load_symbol[IDX_W-1:0]] <= 1'b1;
            end

            if (cmd.shift_bit)
            begin
                acc_reg <= acc_next;
            end
            else if (cmd.take_hit || (cmd.finish && end_reg))
            begin
                acc_reg <= ACC_EMPTY;
            end

            if (cmd.shift_bit)
            begin
                issue_more_reg <= 1'b1;
            end
            else if (issue)
            begin
                issue_more_reg <= (scan_idx_reg != LAST_IDX);
            end
            cmp_pending_reg <= issue;

            if (cmd.take_hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (push)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            byte_reg <= item.data_byte;
            nbits_reg <= nbits_clamped;
            end_reg <= item.stream_end;
            bit_cnt_reg <= 4'd0;
        end
        else if (cmd.shift_bit)
        begin
            byte_reg <= {byte_reg[6:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 4'd1;
        end

        if (cmd.shift_bit)
        begin
            scan_idx_reg <= IDX_W'(1);
        end
        else if (issue)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end

        if (issue)
        begin
            cmp_idx_reg <= rd_addr;
        end
        ent_vld_reg <= vld_reg[rd_addr];

        if (hit && cmd.scan_step)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end

        if (cmd.take_hit)
        begin
            pend_idx_reg <= hit_idx_reg;
        end

        if (push)
        begin
            result_reg.symbol <= 8'(pend_idx_reg);
            result_reg.last_of_item <= push_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/hbd_ctrl.sv
// Controller state machine that sequences requests, bit shifts and table scans.
module hbd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  hbd_pkg::status_t status,
    output hbd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SHIFT,
        ST_SCAN,
        ST_HIT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept = item_valid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_item = 1'b1;
                    if (status.item_load)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.item_empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_bit = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.hit)
                begin
                    state_next = ST_HIT;
                end
                else if (status.scan_miss)
                begin
                    state_next = status.bits_left ? ST_SHIFT : ST_FINISH;
                end
            end
            ST_HIT:
            begin
                if (status.can_push)
                begin
                    cmd.take_hit = 1'b1;
                    state_next = status.bits_left ? ST_SHIFT : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.can_push)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign item_ready = ready_reg;

endmodule

FILE: rtl/core/huffman_bit_decoder.sv
// Top level of the Huffman bit decoder with a sentinel-prefixed code table.
//
//   Channel   Handshake                    Payload
//   item      item_valid / item_ready      item   (hbd_pkg::item_t)
//   result    result_valid / result_ready  result (hbd_pkg::result_t)
//
// A load request writes the code of an in-range symbol into the table. A data request
// takes, for each valid bit, a shift into the accumulator, a scan of the code table
// through its single read port (up to TABLE_ENTRIES entries, stopping at the first
// match), and on a match a hand-over of the symbol; a finish step then ends the request.
// Reset marks every table entry unused and sets the accumulator to its empty sentinel.
// A stalled result register holds the decoder until the result is taken.
module huffman_bit_decoder #(
    parameter int TABLE_ENTRIES = hbd_pkg::TABLE_ENTRIES,
    parameter int CODE_WIDTH = hbd_pkg::CODE_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  hbd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output hbd_pkg::result_t result
);

    hbd_pkg::cmd_t    cmd;
    hbd_pkg::status_t status;

    hbd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    hbd_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CODE_WIDTH    (CODE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
